// ===== rtl/core/lmcd_pkg.sv =====
// shared types, codes and crc helper for the literal/match copy decoder
package lmcd_pkg;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_OFFSET,
    PH_CRC,
    PH_LITERAL,
    PH_MATCH
  } phase_e;

  localparam logic [1:0] ACT_CTRL = 2'd0;
  localparam logic [1:0] ACT_LIT  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_GOOD       = 3'd1;
  localparam logic [2:0] KIND_MISMATCH   = 3'd2;
  localparam logic [2:0] KIND_BAD_OFFSET = 3'd3;
  localparam logic [2:0] KIND_UNEXPECTED = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef struct packed {
    logic        is_data;
    logic        is_copy;
    logic        fwd;
    logic        check;
    logic [2:0]  kind;
    logic [7:0]  lit;
    logic [31:0] exp_crc;
  } stage_t;

  typedef struct packed {
    logic [2:0]  cnt;
    logic [31:0] crc;
    logic        status;
  } emit_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

// ===== rtl/core/lmcd_in_if.sv =====
// input request channel: action code and byte
interface lmcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink (input valid, input action, input in_byte, output ready);
endinterface

// ===== rtl/core/lmcd_out_if.sv =====
// output request channel: result kind and decoded byte
interface lmcd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] out_byte;

  modport source (output valid, output result_kind, output out_byte, input ready);
  modport sink (input valid, input result_kind, input out_byte, output ready);
endinterface

// ===== rtl/core/lmcd_ram.sv =====
// generic single write, single read ram with registered read data
module lmcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lmcd_parse.sv =====
// record parser: header, offset and checksum fields, history read address
module lmcd_parse import lmcd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned AW            = $clog2(HISTORY_DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lmcd_in_if.sink        in_i,
  input  logic           room_i,
  output logic           st_valid_o,
  output stage_t         st_o,
  output logic [AW-1:0]  waddr_o,
  output logic           rd_en_o,
  output logic [AW-1:0]  rd_addr_o
);

  localparam int unsigned AW1 = AW + 1;
  localparam logic [AW1-1:0] DEPTH_A   = AW1'(HISTORY_DEPTH);
  localparam logic [AW-1:0]  LAST_POS  = AW'(HISTORY_DEPTH - 1);
  localparam logic [31:0]    DEPTH_32  = 32'(HISTORY_DEPTH);

  phase_e       phase_q, phase_d;
  logic [7:0]   head_q, head_d;
  logic [1:0]   fbc_q, fbc_d;
  logic [15:0]  rem_q, rem_d;
  logic [31:0]  dist_q, dist_d;
  logic [31:0]  exp_q, exp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [31:0]  bw_q, bw_d;
  logic         prev_data_q, prev_data_d;

  logic         acc;
  logic [1:0]   need;
  logic [31:0]  field_full;
  logic [31:0]  exp_full;
  logic [15:0]  len_full;
  logic [15:0]  rem_dec;
  logic         data;
  logic [AW1-1:0] wpx;
  logic [AW1-1:0] dnar;
  logic [AW1-1:0] src;

  assign acc        = in_i.valid & room_i;
  assign in_i.ready = room_i;
  assign waddr_o    = wp_q;

  assign field_full = dist_q | (32'(in_i.in_byte) << {fbc_q, 3'b000});
  assign exp_full   = exp_q | (32'(in_i.in_byte) << {fbc_q, 3'b000});
  assign len_full   = {in_i.in_byte, rem_q[7:0]};
  assign rem_dec    = rem_q - 16'd1;

  assign wpx  = {1'b0, wp_q};
  assign dnar = dist_q[AW:0];
  assign src  = (wpx >= dnar) ? (wpx - dnar) : (wpx + (DEPTH_A - dnar));
  assign rd_addr_o = src[AW-1:0];

  always_comb begin
    phase_d     = phase_q;
    head_d      = head_q;
    fbc_d       = fbc_q;
    rem_d       = rem_q;
    dist_d      = dist_q;
    exp_d       = exp_q;
    wp_d        = wp_q;
    bw_d        = bw_q;
    st_valid_o  = 1'b0;
    st_o        = '0;
    rd_en_o     = 1'b0;
    data        = 1'b0;

    case (phase_q)
      PH_LITERAL: need = ACT_LIT;
      PH_MATCH:   need = ACT_TICK;
      default:    need = ACT_CTRL;
    endcase

    if (acc) begin
      if (in_i.action != need) begin
        st_valid_o = 1'b1;
        st_o.kind  = KIND_UNEXPECTED;
        phase_d    = PH_HEAD;
        head_d     = '0;
        fbc_d      = '0;
        rem_d      = '0;
        dist_d     = '0;
        exp_d      = '0;
      end else begin
        case (phase_q)
          PH_HEAD: begin
            head_d  = in_i.in_byte;
            rem_d   = '0;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            rem_d   = {8'h00, in_i.in_byte};
            phase_d = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            rem_d = len_full;
            fbc_d = '0;
            if (head_q != 8'h00) begin
              dist_d  = '0;
              phase_d = PH_OFFSET;
            end else if (len_full == 16'h0000) begin
              exp_d   = '0;
              phase_d = PH_CRC;
            end else begin
              phase_d = PH_LITERAL;
            end
          end
          PH_OFFSET: begin
            dist_d = field_full;
            if (fbc_q != 2'd3) begin
              fbc_d = fbc_q + 2'd1;
            end else begin
              fbc_d = '0;
              if (field_full == 32'h0 || field_full > bw_q || field_full > DEPTH_32) begin
                st_valid_o = 1'b1;
                st_o.kind  = KIND_BAD_OFFSET;
                phase_d    = PH_HEAD;
                head_d     = '0;
                rem_d      = '0;
                dist_d     = '0;
                exp_d      = '0;
              end else begin
                phase_d = (rem_q != 16'h0000) ? PH_MATCH : PH_HEAD;
              end
            end
          end
          PH_CRC: begin
            if (fbc_q != 2'd3) begin
              exp_d = exp_full;
              fbc_d = fbc_q + 2'd1;
            end else begin
              st_valid_o   = 1'b1;
              st_o.check   = 1'b1;
              st_o.exp_crc = exp_full;
              phase_d      = PH_HEAD;
              head_d       = '0;
              fbc_d        = '0;
              rem_d        = '0;
              dist_d       = '0;
              exp_d        = '0;
            end
          end
          PH_LITERAL: begin
            data     = 1'b1;
            st_o.lit = in_i.in_byte;
          end
          PH_MATCH: begin
            data         = 1'b1;
            rd_en_o      = 1'b1;
            st_o.is_copy = 1'b1;
            // copy at distance one reads the byte still being written
            st_o.fwd     = (dist_q == 32'd1) && prev_data_q;
          end
          default: begin
            phase_d = PH_HEAD;
          end
        endcase
      end
    end

    if (data) begin
      st_valid_o   = 1'b1;
      st_o.is_data = 1'b1;
      st_o.kind    = KIND_DATA;
      wp_d         = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
      bw_d         = (bw_q == 32'hFFFFFFFF) ? bw_q : bw_q + 32'd1;
      rem_d        = rem_dec;
      if (rem_dec == 16'h0000) begin
        phase_d = PH_HEAD;
      end
    end

    prev_data_d = data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      head_q      <= '0;
      fbc_q       <= '0;
      rem_q       <= '0;
      dist_q      <= '0;
      exp_q       <= '0;
      wp_q        <= '0;
      bw_q        <= '0;
      prev_data_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      head_q      <= head_d;
      fbc_q       <= fbc_d;
      rem_q       <= rem_d;
      dist_q      <= dist_d;
      exp_q       <= exp_d;
      wp_q        <= wp_d;
      bw_q        <= bw_d;
      prev_data_q <= prev_data_d;
    end
  end

endmodule

// ===== rtl/core/lmcd_emit.sv =====
// emit stage: byte select, history write, crc update and output queue
module lmcd_emit import lmcd_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              st_valid_i,
  input  stage_t            st_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        rdata_i,
  output logic              room_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [7:0]        wdata_o,
  output emit_stat_t        stat_o,
  lmcd_out_if.source        out_o
);

  logic              b_valid_q;
  stage_t            b_q;
  logic [ADDR_W-1:0] b_waddr_q;
  logic [7:0]        last_q;
  logic [31:0]       crc_q, crc_d;

  logic [10:0]       q_mem [4];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        cnt_q, cnt_d;

  logic [7:0]        byte_sel;
  logic [2:0]        kind;
  logic [7:0]        res_byte;
  logic              push, pop;
  logic [2:0]        occ;

  assign byte_sel = b_q.is_copy ? (b_q.fwd ? last_q : rdata_i) : b_q.lit;
  assign res_byte = b_q.is_data ? byte_sel : 8'h00;

  always_comb begin
    if (b_q.is_data) begin
      kind = KIND_DATA;
    end else if (b_q.check) begin
      kind = (b_q.exp_crc == crc_q) ? KIND_GOOD : KIND_MISMATCH;
    end else begin
      kind = b_q.kind;
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (b_valid_q) begin
      crc_d = b_q.is_data ? crc_byte(crc_q, byte_sel) : 32'h0;
    end
  end

  assign we_o    = b_valid_q & b_q.is_data;
  assign waddr_o = b_waddr_q;
  assign wdata_o = byte_sel;

  assign push  = b_valid_q;
  assign pop   = out_o.valid & out_o.ready;
  assign occ   = cnt_q + {2'b00, b_valid_q};
  assign room_o = (occ <= 3'd3);
  assign cnt_d = cnt_q + {2'b00, push} - {2'b00, pop};

  assign out_o.valid       = (cnt_q != 3'd0);
  assign out_o.result_kind = q_mem[rd_ptr_q][10:8];
  assign out_o.out_byte    = q_mem[rd_ptr_q][7:0];

  assign stat_o.cnt    = cnt_q;
  assign stat_o.crc    = crc_q;
  assign stat_o.status = b_valid_q & ~b_q.is_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      crc_q     <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      b_valid_q <= st_valid_i;
      crc_q     <= crc_d;
      cnt_q     <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_q       <= st_i;
    b_waddr_q <= waddr_i;
    if (we_o) begin
      last_q <= byte_sel;
    end
    if (push) begin
      q_mem[wr_ptr_q] <= {kind, res_byte};
    end
  end

endmodule

// ===== rtl/core/literal_match_copy_decoder.sv =====
// top level of the literal/match copy decoder with crc-32 chunk check
//
// in_i carries one request per item: a control byte, a literal byte or a
// copy tick. out_o carries zero or one result per item: a decoded byte or
// a chunk status (checksum good, mismatch, bad offset, unexpected item).
// throughput is one item per cycle while in_i.ready is high; each item makes
// at most one read and one write of the history ram, and one crc byte update
// in the emit stage. each result is registered before it reaches out_o.
// a four-entry output queue sits behind the emit stage; while the receiver
// stalls the queue fills and in_i.ready drops once queue plus in-flight
// results reach four, so no result is lost.
// copies at distance one are forwarded from the byte being written.
// reset clears the parser, counters, crc and queue at once; the history ram
// is not cleared, and offsets are checked so that only written entries are
// read.
module literal_match_copy_decoder import lmcd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmcd_in_if.sink    in_i,
  lmcd_out_if.source out_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic          room;
  logic          st_valid;
  stage_t        st;
  logic [AW-1:0] st_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  emit_stat_t    stat;

  lmcd_parse #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .room_i     (room),
    .st_valid_o (st_valid),
    .st_o       (st),
    .waddr_o    (st_waddr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  lmcd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  lmcd_emit #(
    .ADDR_W (AW)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_valid_i (st_valid),
    .st_i       (st),
    .waddr_i    (st_waddr),
    .rdata_i    (rdata),
    .room_o     (room),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .stat_o     (stat),
    .out_o      (out_o)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt <= 3'd4)
    else $error("output queue overfilled");

  a_status_clears_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.status |=> stat.crc == 32'h0)
    else $error("crc not cleared after chunk status");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind != KIND_DATA) |-> out_o.out_byte == 8'h00)
    else $error("status result carries a nonzero byte");

endmodule
